// ===== hw/rtl/ocp_pkg.sv =====
`default_nettype none
package ocp_pkg;

	// Largest valid variable index
	localparam int MAX_VAR_INDEX = 46340;
	localparam logic [63:0] MAX_IDX = 64'(MAX_VAR_INDEX);
	// Largest position that decodes to a constraint
	localparam logic [63:0] POS_LIMIT = 64'd2 * MAX_IDX * MAX_IDX;

	localparam int POS_W = 32;
	localparam int IDX_W = 16;
	localparam int SQ_W = 16;          // root bits of a 32-bit radicand
	localparam int REM_W = SQ_W + 4;   // partial remainder
	localparam int ITER_PER_STAGE = 4;
	localparam int SQRT_STAGES = SQ_W / ITER_PER_STAGE;

	typedef logic [1:0] sgn_t;
	localparam sgn_t SGN_NEG = 2'd0;
	localparam sgn_t SGN_ZERO = 2'd1;
	localparam sgn_t SGN_POS = 2'd2;
	localparam sgn_t SGN_BAD = 2'd3;

	localparam logic MODE_DECODE = 1'b0;
	localparam logic MODE_ENCODE = 1'b1;

	// Input item as held in the pipeline
	typedef struct packed {
		logic             mode;
		logic [POS_W-1:0] pos;
		sgn_t             s1;
		logic [IDX_W-1:0] i1;
		sgn_t             s2;
		logic [IDX_W-1:0] i2;
	} ocp_req_t;

	// Item travelling through the root stages
	typedef struct packed {
		ocp_req_t         req;
		logic             is_zero;
		logic             over;
		logic             enc_bad;
		logic [POS_W-1:0] x;
		logic [REM_W-1:0] rem;
		logic [SQ_W-1:0]  root;
	} ocp_sq_t;

	// Result item
	typedef struct packed {
		logic [POS_W-1:0] pos;
		sgn_t             s1;
		logic [IDX_W-1:0] i1;
		sgn_t             s2;
		logic [IDX_W-1:0] i2;
		logic             invalid;
	} ocp_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ocp_in_if.sv =====
`default_nettype none
interface ocp_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] position_in;
	logic [1:0]  sign_first_in;
	logic [15:0] index_first_in;
	logic [1:0]  sign_second_in;
	logic [15:0] index_second_in;

	modport source (
		output valid, mode, position_in, sign_first_in, index_first_in,
		       sign_second_in, index_second_in,
		input  ready
	);
	modport sink (
		input  valid, mode, position_in, sign_first_in, index_first_in,
		       sign_second_in, index_second_in,
		output ready
	);
endinterface
`default_nettype wire

// ===== hw/rtl/ocp_out_if.sv =====
`default_nettype none
interface ocp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] position_out;
	logic [1:0]  sign_first_out;
	logic [15:0] index_first_out;
	logic [1:0]  sign_second_out;
	logic [15:0] index_second_out;
	logic        invalid;

	modport source (
		output valid, position_out, sign_first_out, index_first_out,
		       sign_second_out, index_second_out, invalid,
		input  ready
	);
	modport sink (
		input  valid, position_out, sign_first_out, index_first_out,
		       sign_second_out, index_second_out, invalid,
		output ready
	);
endinterface
`default_nettype wire

// ===== hw/rtl/ocp_front.sv =====
`default_nettype none
module ocp_front (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire ocp_pkg::ocp_req_t req,
	output ocp_pkg::ocp_sq_t     sq_s1
);
	import ocp_pkg::*;

	logic [POS_W-1:0] pos_m1;
	logic             bad;

	// Range and consistency checks, radicand for the root
	always_comb begin
		pos_m1 = req.pos - POS_W'(1);
		bad = 1'b0;
		if (req.s1 == SGN_BAD || req.s2 == SGN_BAD) bad = 1'b1;
		if (req.i1 == '0 || {48'd0, req.i1} > MAX_IDX) bad = 1'b1;
		if (req.s2 != SGN_ZERO && (req.i2 == '0 || req.i2 >= req.i1)) bad = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1.req     <= req;
			sq_s1.is_zero <= (req.pos == '0);
			sq_s1.over    <= ({32'd0, req.pos} > POS_LIMIT);
			sq_s1.enc_bad <= bad;
			sq_s1.x       <= {1'b0, pos_m1[POS_W-1:1]};
			sq_s1.rem     <= '0;
			sq_s1.root    <= '0;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ocp_sqrt_stage.sv =====
`default_nettype none
module ocp_sqrt_stage (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire ocp_pkg::ocp_sq_t d,
	output ocp_pkg::ocp_sq_t   q
);
	import ocp_pkg::*;

	logic [POS_W-1:0] x;
	logic [REM_W-1:0] rem;
	logic [REM_W-1:0] trial;
	logic [SQ_W-1:0]  root;

	// Digit-by-digit root, two radicand bits per iteration
	always_comb begin
		x = d.x;
		rem = d.rem;
		root = d.root;
		trial = '0;
		for (int k = 0; k < ITER_PER_STAGE; k++) begin
			rem = {rem[REM_W-3:0], x[POS_W-1:POS_W-2]};
			x = {x[POS_W-3:0], 2'b00};
			trial = {2'b00, root, 2'b01};
			if (rem >= trial) begin
				rem = rem - trial;
				root = {root[SQ_W-2:0], 1'b1};
			end else begin
				root = {root[SQ_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q.req     <= d.req;
			q.is_zero <= d.is_zero;
			q.over    <= d.over;
			q.enc_bad <= d.enc_bad;
			q.x       <= x;
			q.rem     <= rem;
			q.root    <= root;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ocp_finish.sv =====
`default_nettype none
module ocp_finish (
	input  wire logic          clk,
	input  wire logic          en_mul,
	input  wire logic          en_out,
	input  wire ocp_pkg::ocp_sq_t d,
	output ocp_pkg::ocp_rsp_t  rsp_s7
);
	import ocp_pkg::*;

	ocp_req_t         req_s6;
	logic             is_zero_s6;
	logic             over_s6;
	logic             enc_bad_s6;
	logic [SQ_W-1:0]  root_s6;
	logic [POS_W-1:0] sq_s6;
	logic [18:0]      off_s6;

	logic [SQ_W-1:0]  m;
	logic [17:0]      off_a;
	logic [17:0]      off_b;
	logic [IDX_W-1:0] i1_m1;
	logic [IDX_W-1:0] i2_m1;

	// Shared square: group root when decoding, first index less one when encoding
	always_comb begin
		i1_m1 = d.req.i1 - IDX_W'(1);
		i2_m1 = d.req.i2 - IDX_W'(1);
		m = (d.req.mode == MODE_ENCODE) ? i1_m1 : d.root;
		off_a = (d.req.s1 == SGN_POS) ? ({1'b0, i1_m1, 1'b0} + 18'd1) : '0;
		unique case (d.req.s2)
			SGN_NEG: off_b = {1'b0, i2_m1, 1'b0} + 18'd1;
			SGN_POS: off_b = {1'b0, i2_m1, 1'b0} + 18'd2;
			default: off_b = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_mul) begin
			req_s6     <= d.req;
			is_zero_s6 <= d.is_zero;
			over_s6    <= d.over;
			enc_bad_s6 <= d.enc_bad;
			root_s6    <= d.root;
			sq_s6      <= POS_W'(m) * POS_W'(m);
			off_s6     <= {1'b0, off_a} + {1'b0, off_b};
		end
	end

	logic [33:0]      base;
	logic [33:0]      rel;
	logic [33:0]      half;
	logic [33:0]      sep;
	logic [33:0]      sep_p1;
	logic [33:0]      sum;
	ocp_rsp_t         res;

	// Group offset, signs and second index; or encoded position
	always_comb begin
		base = {1'b0, sq_s6, 1'b0} + 34'd1;
		half = {17'd0, root_s6, 1'b0};
		rel = {2'b00, req_s6.pos} - base;
		sum = base + {15'd0, off_s6};
		sep = '0;
		sep_p1 = '0;
		res.pos = req_s6.pos;
		res.s1 = SGN_ZERO;
		res.i1 = '0;
		res.s2 = SGN_ZERO;
		res.i2 = '0;
		res.invalid = 1'b0;
		if (req_s6.mode == MODE_DECODE) begin
			if (is_zero_s6) begin
				res.pos = '0;
			end else if (over_s6) begin
				res.invalid = 1'b1;
			end else begin
				if (rel <= half) begin
					res.s1 = SGN_NEG;
					sep = rel;
				end else begin
					res.s1 = SGN_POS;
					sep = rel - half - 34'd1;
				end
				sep_p1 = sep + 34'd1;
				res.i1 = root_s6 + IDX_W'(1);
				if (sep != '0) begin
					res.s2 = sep[0] ? SGN_NEG : SGN_POS;
					res.i2 = sep_p1[IDX_W:1];
				end
			end
		end else begin
			res.s1 = req_s6.s1;
			res.i1 = req_s6.i1;
			res.s2 = req_s6.s2;
			res.i2 = req_s6.i2;
			priority if (req_s6.s1 == SGN_ZERO) begin
				res.pos = '0;
			end else if (enc_bad_s6 || sum[33:32] != 2'b00) begin
				res.pos = '0;
				res.invalid = 1'b1;
			end else begin
				res.pos = sum[POS_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) rsp_s7 <= res;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/octagon_position_codec_core.sv =====
// Octagon position codec: seven register stages, from the input register to the result register.
// Throughput one item per cycle while the output is ready; the stage count is set by the 16-step integer root,
// four steps per stage, plus input, square and result stages.
// Each stage moves on when the next one is empty or moving, so stalls hold all items.
// Asynchronous active-low reset clears the valid bits only; no clearing pass.
`default_nettype none
module octagon_position_codec_core (
	input  wire logic clk,
	input  wire logic arst_n,
	ocp_in_if.sink    req,
	ocp_out_if.source rsp
);
	import ocp_pkg::*;

	localparam int NSTG = SQRT_STAGES + 3;

	logic [NSTG:1] vld_q;   // one valid bit per stage
	logic [NSTG:1] adv;     // stage may load
	ocp_req_t      req_item;
	ocp_sq_t       sq [0:SQRT_STAGES];
	ocp_rsp_t      rsp_s7;

	// Ready chain from the output backwards
	always_comb begin
		adv[NSTG] = !vld_q[NSTG] || rsp.ready;
		for (int k = NSTG - 1; k >= 1; k--) adv[k] = !vld_q[k] || adv[k+1];
	end

	assign req.ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= req.valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Input item
	always_comb begin
		req_item.mode = req.mode;
		req_item.pos  = req.position_in;
		req_item.s1   = req.sign_first_in;
		req_item.i1   = req.index_first_in;
		req_item.s2   = req.sign_second_in;
		req_item.i2   = req.index_second_in;
	end

	ocp_front u_front (
		.clk   (clk),
		.en    (adv[1]),
		.req   (req_item),
		.sq_s1 (sq[0])
	);

	// Root stages
	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
		ocp_sqrt_stage u_stage (
			.clk (clk),
			.en  (adv[g+2]),
			.d   (sq[g]),
			.q   (sq[g+1])
		);
	end

	ocp_finish u_finish (
		.clk    (clk),
		.en_mul (adv[NSTG-1]),
		.en_out (adv[NSTG]),
		.d      (sq[SQRT_STAGES]),
		.rsp_s7 (rsp_s7)
	);

	assign rsp.valid            = vld_q[NSTG];
	assign rsp.position_out     = rsp_s7.pos;
	assign rsp.sign_first_out   = rsp_s7.s1;
	assign rsp.index_first_out  = rsp_s7.i1;
	assign rsp.sign_second_out  = rsp_s7.s2;
	assign rsp.index_second_out = rsp_s7.i2;
	assign rsp.invalid          = rsp_s7.invalid;
endmodule
`default_nettype wire
